[hdl/fdl_pkg.sv]
// ----------------------------------------------------------------------------
// fdl_pkg
// Types, register indexes, gain limits and saturation shared by the echo
// delay line blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

    typedef logic signed [15:0] t_sample;
    typedef logic [1:0]         t_cfg_idx;

    localparam t_cfg_idx CFG_DELAY_LENGTH  = 2'd0;
    localparam t_cfg_idx CFG_FEEDBACK_GAIN = 2'd1;
    localparam t_cfg_idx CFG_MIX_GAIN      = 2'd2;
    localparam t_cfg_idx CFG_CHANNEL_COUNT = 2'd3;

    // feedback capped at 0.99 in q0.15, mix capped at unity
    localparam logic [14:0] FB_CAP = 15'd32440;
    localparam logic [15:0] UNITY  = 16'd32768;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [14:0] feedback;
        logic [15:0] mix;
    } t_gains;

    function automatic t_sample f_sat16(input logic signed [18:0] v);
        t_sample r;
        if (v > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = t_sample'(v[15:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/fdl_sample_if.sv]
// ----------------------------------------------------------------------------
// fdl_sample_if
// Input stream channel carrying one dry sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdl_sample_if;
    logic             valid;
    logic             ready;
    fdl_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hdl/fdl_result_if.sv]
// ----------------------------------------------------------------------------
// fdl_result_if
// Output stream channel carrying one mixed sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdl_result_if;
    logic             valid;
    logic             ready;
    fdl_pkg::t_sample result_sample;

    modport source (output valid, output result_sample, input ready);
    modport sink   (input valid, input result_sample, output ready);
endinterface

`default_nettype wire

[hdl/fdl_cfg_if.sv]
// ----------------------------------------------------------------------------
// fdl_cfg_if
// Register write channel: one register index and its data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdl_cfg_if;
    logic              valid;
    logic              ready;
    fdl_pkg::t_cfg_idx index;
    logic [15:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/feedback_delay_line.sv]
// ----------------------------------------------------------------------------
// feedback_delay_line
// Multichannel feedback echo over interleaved samples with one shared
// write position per frame and a per-channel delay line in block memory.
// ----------------------------------------------------------------------------
//  channel  dir  payload            handshake
//  i_cfg    in   index, data        valid/ready, ready always high
//  i_in     in   sample             valid/ready
//  o_out    out  result_sample      valid/ready
//
//  one sample beat per cycle while i_in.ready is high; staged in s1, s2, s3
//  the rate is set by the forward, feedback multiply, saturate loop
//  after reset the line memory is swept to zero, one entry per cycle, over all
//  MAX_CHANNELS * LINE_DEPTH entries (65536 by default), with i_in.ready low
//  an eight-entry result queue absorbs output stalls; i_in.ready drops once
//  eight beats are outstanding
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_delay_line #(
    parameter int LINE_DEPTH   = 32768,
    parameter int MAX_CHANNELS = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fdl_cfg_if.sink      i_cfg,
    fdl_sample_if.sink   i_in,
    fdl_result_if.source o_out
);
    import fdl_pkg::*;

    localparam int MEM_DEPTH = MAX_CHANNELS * LINE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int POS_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LEN_W     = (POS_W + 1 > 17) ? POS_W + 1 : 17;
    localparam int CNT_W     = 4;

    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LINE_DEPTH);
    localparam logic [CNT_W-1:0] CHAN_MAX = CNT_W'(MAX_CHANNELS);

    logic [15:0]        r_delay_length;
    logic [14:0]        r_feedback_gain;
    logic [15:0]        r_mix_gain;
    logic [1:0]         r_channel_count;

    logic [CH_W-1:0]    r_ch;
    logic [POS_W-1:0]   r_pos;
    logic [FIFO_AW:0]   r_credit;
    logic [FIFO_AW:0]   n_credit;

    t_gains             w_gains;
    logic [LEN_W-1:0]   w_len_raw;
    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_pos_inc;
    logic [CNT_W-1:0]   w_cnt_raw;
    logic [CNT_W-1:0]   w_chans;
    logic [CNT_W-1:0]   w_ch_inc;
    logic               w_frame_end;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_busy;
    logic               w_in_fire;
    logic               w_pop;
    logic               w_res_valid;
    t_sample            w_res_sample;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= 16'd1;
            r_feedback_gain <= 15'd0;
            r_mix_gain      <= 16'd16384;
            r_channel_count <= 2'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg.data;
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg.data[14:0];
                CFG_MIX_GAIN:      r_mix_gain      <= i_cfg.data;
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[1:0];
                default: begin
                end
            endcase
        end
    end

    // effective settings after limiting
    assign w_gains.feedback = (r_feedback_gain > FB_CAP) ? FB_CAP : r_feedback_gain;
    assign w_gains.mix      = (r_mix_gain > UNITY) ? UNITY : r_mix_gain;

    assign w_len_raw = LEN_W'(r_delay_length);
    assign w_len     = (w_len_raw == '0) ? LEN_W'(1)
                     : ((w_len_raw > LEN_MAX) ? LEN_MAX : w_len_raw);

    assign w_cnt_raw = CNT_W'(r_channel_count);
    assign w_chans   = (w_cnt_raw == '0) ? CNT_W'(1)
                     : ((w_cnt_raw > CHAN_MAX) ? CHAN_MAX : w_cnt_raw);

    assign w_ch_inc    = CNT_W'(r_ch) + 1'b1;
    assign w_frame_end = (w_ch_inc >= w_chans);
    assign w_pos_inc   = LEN_W'(r_pos) + 1'b1;

    assign w_addr = ADDR_W'(r_ch) * ADDR_W'(LINE_DEPTH) + ADDR_W'(r_pos);

    assign i_in.ready = !w_busy && (r_credit < (FIFO_AW + 1)'(FIFO_DEPTH));
    assign w_in_fire  = i_in.valid & i_in.ready;
    assign w_pop      = o_out.valid & o_out.ready;

    always_comb begin
        n_credit = r_credit;
        if (w_in_fire && !w_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (!w_in_fire && w_pop) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch     <= '0;
            r_pos    <= '0;
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
            if (w_in_fire) begin
                if (w_frame_end) begin
                    r_ch  <= '0;
                    r_pos <= (w_pos_inc >= w_len) ? '0 : POS_W'(w_pos_inc);
                end else begin
                    r_ch <= CH_W'(w_ch_inc);
                end
            end
        end
    end

    fdl_echo #(
        .MEM_DEPTH (MEM_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_echo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_in_fire),
        .i_addr       (w_addr),
        .i_dry        (i_in.sample),
        .i_gains      (w_gains),
        .o_busy       (w_busy),
        .o_res_valid  (w_res_valid),
        .o_res_sample (w_res_sample)
    );

    fdl_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_push_data (w_res_sample),
        .o_out       (o_out)
    );

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("outstanding beats exceed result queue");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_credit != '0))
        else $error("result beat without an outstanding sample");

    a_frame_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_frame_end) |=> (r_ch == '0))
        else $error("channel index did not return to zero at frame end");

    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_ch) < CHAN_MAX)
        else $error("channel index beyond channel limit");
`endif

endmodule

`default_nettype wire

[hdl/fdl_fifo.sv]
// ----------------------------------------------------------------------------
// fdl_fifo
// Small result queue that decouples the fixed-latency pipeline from the
// output handshake. The caller guarantees room before each push.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fdl_pkg::t_sample i_push_data,
    fdl_result_if.source     o_out
);
    import fdl_pkg::*;

    t_sample            r_data [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_fill;
    logic [FIFO_AW:0]   n_fill;
    logic               w_pop;

    assign w_pop               = o_out.valid & o_out.ready;
    assign o_out.valid         = (r_fill != '0);
    assign o_out.result_sample = r_data[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (i_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && w_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/fdl_echo.sv]
// ----------------------------------------------------------------------------
// fdl_echo
// Delay line memory with its read-modify-write pipeline: read the delayed
// sample, write back dry plus scaled feedback, and mix dry and wet.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_echo #(
    parameter int MEM_DEPTH = 65536,
    parameter int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [ADDR_W-1:0] i_addr,
    input  fdl_pkg::t_sample  i_dry,
    input  fdl_pkg::t_gains   i_gains,
    output logic              o_busy,
    output logic              o_res_valid,
    output fdl_pkg::t_sample  o_res_sample
);
    import fdl_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

    logic [15:0]        r_mem [MEM_DEPTH];
    t_sample            r_rd_data;

    logic               r_clr_busy;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic               r_s1_valid;
    logic [ADDR_W-1:0]  r_s1_addr;
    t_sample            r_s1_dry;

    logic               r_wr_valid;
    logic [ADDR_W-1:0]  r_wr_addr;
    t_sample            r_wr_data;

    logic               r_s2_valid;
    t_sample            r_s2_dry;
    logic signed [16:0] r_s2_diff;

    logic               r_s3_valid;
    t_sample            r_s3_dry;
    logic signed [33:0] r_s3_prod;

    t_sample            w_delayed;
    logic signed [15:0] w_fb_s;
    logic signed [31:0] w_fb_prod;
    logic signed [31:0] w_fb_round;
    logic signed [16:0] w_fb_q;
    logic signed [18:0] w_wr_sum;
    t_sample            w_wr_data;
    logic signed [16:0] w_diff;
    logic signed [16:0] w_mix_s;
    logic signed [33:0] w_mix_prod;
    logic signed [33:0] w_mix_sum;

    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_waddr;
    logic [15:0]        w_mem_wdata;

    // the previous item wrote this entry on the edge that did our read
    assign w_delayed = (r_wr_valid && (r_wr_addr == r_s1_addr)) ? r_wr_data : r_rd_data;

    assign w_fb_s     = signed'({1'b0, i_gains.feedback});
    assign w_fb_prod  = w_delayed * w_fb_s;
    assign w_fb_round = w_fb_prod + 32'sd16384;
    assign w_fb_q     = signed'(w_fb_round[31:15]);
    assign w_wr_sum   = signed'({{3{r_s1_dry[15]}}, r_s1_dry})
                      + signed'({{2{w_fb_q[16]}}, w_fb_q});
    assign w_wr_data  = f_sat16(w_wr_sum);

    // dry*(1-mix) + wet*mix folded into dry + (wet-dry)*mix
    assign w_diff     = signed'({w_delayed[15], w_delayed}) - signed'({r_s1_dry[15], r_s1_dry});
    assign w_mix_s    = signed'({1'b0, i_gains.mix});
    assign w_mix_prod = r_s2_diff * w_mix_s;
    assign w_mix_sum  = signed'({{3{r_s3_dry[15]}}, r_s3_dry, 15'd0}) + r_s3_prod
                      + 34'sd16384;

    assign w_mem_we    = r_clr_busy | r_s1_valid;
    assign w_mem_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign w_mem_wdata = r_clr_busy ? 16'd0 : w_wr_data;

    assign o_busy       = r_clr_busy;
    assign o_res_valid  = r_s3_valid;
    assign o_res_sample = f_sat16(signed'(w_mix_sum[33:15]));

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (i_req_valid) begin
            r_rd_data <= t_sample'(r_mem[i_addr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_valid <= i_req_valid;
            r_wr_valid <= r_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_addr;
        r_s1_dry  <= i_dry;
        r_wr_addr <= r_s1_addr;
        r_wr_data <= w_wr_data;
        r_s2_dry  <= r_s1_dry;
        r_s2_diff <= w_diff;
        r_s3_dry  <= r_s2_dry;
        r_s3_prod <= w_mix_prod;
    end

`ifndef SYNTH
    a_no_req_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_req_valid)
        else $error("sample beat taken during line clear");

    a_pipe_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid |=> r_s1_valid ##1 r_s2_valid ##1 r_s3_valid)
        else $error("pipeline dropped a beat");

    a_clear_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_busy && !$past(r_clr_busy)) |-> (r_clr_addr == '0))
        else $error("line clear restarted mid sweep");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the feedback echo delay line: random and directed
// sample streams under changing register settings, with a
// predictor of the per-channel lines checked against every output beat.
// ----------------------------------------------------------------------------

module tb;

    import fdl_pkg::*;

    localparam int LINE_LEN  = 32768;
    localparam int CHAN_MAX  = 2;

    class echo_scoreboard;
        t_sample     expected_q[$];
        bit [15:0]   line_mem [0:CHAN_MAX*LINE_LEN-1];
        int unsigned line_pos;
        int unsigned chan_idx;
        int unsigned delay_len;
        int unsigned fb_gain;
        int unsigned mix_gain;
        int unsigned chan_count;
        int          errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            line_pos   = 0;
            chan_idx   = 0;
            delay_len  = 1;
            fb_gain    = 0;
            mix_gain   = 16384;
            chan_count = 1;
            errors     = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_DELAY_LENGTH:  delay_len  = data;
                CFG_FEEDBACK_GAIN: fb_gain    = data[14:0];
                CFG_MIX_GAIN:      mix_gain   = data;
                CFG_CHANNEL_COUNT: chan_count = data[1:0];
                default: ;
            endcase
        endfunction

        // q15 product back to sample scale, half rounds up
        function longint round_q15(longint p);
            return (p + 16384) >>> 15;
        endfunction

        function t_sample clip16(longint v);
            if (v > 32767)  return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return t_sample'(v[15:0]);
        endfunction

        function void note_sample(t_sample dry);
            int unsigned len, fb, mix, chans, ch, pos, addr;
            longint      d, dl;
            t_sample     wr;
            len   = (delay_len == 0) ? 1 : ((delay_len > LINE_LEN) ? LINE_LEN : delay_len);
            fb    = (fb_gain > FB_CAP) ? FB_CAP : fb_gain;
            mix   = (mix_gain > UNITY) ? UNITY : mix_gain;
            chans = (chan_count == 0) ? 1 : ((chan_count > CHAN_MAX) ? CHAN_MAX : chan_count);
            ch    = chan_idx % CHAN_MAX;
            pos   = line_pos % LINE_LEN;
            addr  = ch * LINE_LEN + pos;
            d     = longint'(dry);
            dl    = longint'($signed(line_mem[addr]));
            wr    = clip16(d + round_q15(dl * longint'(fb)));
            line_mem[addr] = wr;
            expected_q.push_back(clip16(round_q15(d * longint'(UNITY - mix)
                                                  + dl * longint'(mix))));
            // frame ends on the last channel, or on a stale index past a lowered count
            if (chan_idx + 1 >= chans) begin
                chan_idx = 0;
                line_pos = (line_pos + 1 >= len) ? 0 : line_pos + 1;
            end else begin
                chan_idx++;
            end
        endfunction

        function void check_result(t_sample got);
            t_sample want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %0d",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: result_sample mismatch, expected %0d, actual %0d",
                         $time, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flag_leftover();
            if (expected_q.size() != 0) begin
                errors++;
                $display("%0t: %0d results never arrived, oldest expected %0d, actual none",
                         $time, expected_q.size(), expected_q[0]);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fdl_cfg_if    cfg_if ();
    fdl_sample_if in_if ();
    fdl_result_if out_if ();

    feedback_delay_line dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    echo_scoreboard sb = new();

    bit send_calm;
    bit recv_calm;
    bit hold_output;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.set_register(idx, data);
    endtask

    task automatic program_regs(input logic [15:0] dl, input logic [15:0] fb,
                                input logic [15:0] mix, input logic [15:0] chans);
        write_reg(CFG_DELAY_LENGTH, dl);
        write_reg(CFG_FEEDBACK_GAIN, fb);
        write_reg(CFG_MIX_GAIN, mix);
        write_reg(CFG_CHANNEL_COUNT, chans);
        cfg_if.valid <= 1'b0;
    endtask

    // leaves valid high after the beat, so back-to-back beats keep valid high without a gap
    task automatic push_sample(input t_sample s);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_sample(s);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return t_sample'(int'($urandom_range(0, 64)) - 32);
            default: return t_sample'($urandom);
        endcase
    endfunction

    initial begin : result_sink
        int gap;
        forever begin
            if (hold_output) begin
                gap = 150;
                hold_output = 1'b0;
            end else begin
                gap = recv_calm ? 0 : $urandom_range(0, 8);
            end
            repeat (gap) begin
                out_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result(out_if.result_sample);
    end

    initial begin : stimulus
        int          total;
        int          phase;
        int          n;
        logic [15:0] dl, fb, mix, chans;

        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_DELAY_LENGTH;
        cfg_if.data  <= '0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        hold_output  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, sample extremes
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(16'shffff);
        push_sample(16'sh0001);
        push_sample(16'sh5555);
        drain_results();

        // zero length, feedback and mix above their caps, zero channel count
        program_regs(16'd0, 16'hffff, 16'hffff, 16'd0);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        drain_results();

        // length above the line, full feedback, fully dry, count above max;
        // odd beat count leaves the channel index on the second channel
        program_regs(16'hffff, 16'd32440, 16'd0, 16'd3);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh3039);
        push_sample(16'shffff);
        push_sample(16'sh7fff);
        drain_results();

        // count lowered under the stale index, length lowered under the position
        program_regs(16'd2, 16'd16000, 16'd32768, 16'd1);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh1234);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        drain_results();

        total = 0;
        phase = 0;
        while (total < 1200) begin
            case ($urandom_range(0, 9))
                0:       dl = 16'd0;
                1:       dl = 16'd32768;
                2:       dl = 16'($urandom);
                3:       dl = 16'($urandom_range(40, 400));
                default: dl = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       fb = 16'd0;
                1:       fb = 16'd32440;
                2:       fb = 16'($urandom);
                default: fb = 16'($urandom_range(16000, 32767));
            endcase
            case ($urandom_range(0, 5))
                0:       mix = 16'd0;
                1:       mix = 16'd32768;
                2:       mix = 16'($urandom);
                default: mix = 16'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 5))
                0:       chans = 16'd0;
                1:       chans = 16'd3;
                2, 3:    chans = 16'd1;
                default: chans = 16'd2;
            endcase
            program_regs(dl, fb, mix, chans);

            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            // one phase backs up the output while the input keeps streaming
            if (phase == 2) begin
                send_calm   = 1'b1;
                hold_output = 1'b1;
            end
            n = $urandom_range(20, 90);
            for (int k = 0; k < n; k++) begin
                if (phase == 4 && k == n / 2)
                    drain_results();
                push_sample(pick_sample());
            end
            drain_results();
            total += n;
            phase++;
        end

        repeat (16) @(posedge i_clk);
        sb.flag_leftover();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/fdl_pkg.sv
hdl/fdl_sample_if.sv
hdl/fdl_result_if.sv
hdl/fdl_cfg_if.sv
hdl/fdl_fifo.sv
hdl/fdl_echo.sv
hdl/feedback_delay_line.sv
tb/tb.sv
